>>> src/dps_pkg.sv
// Shared types and constants of the dynamic priority scheduler.
`timescale 1ns / 1ps

package dps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 56;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic REG_TIME_SLICE    = 1'b0;
  localparam logic REG_PRIORITY_STEP = 1'b1;

  localparam logic [15:0] TIME_SLICE_RESET    = 16'd10;
  localparam logic [6:0]  PRIORITY_STEP_RESET = 7'd1;

  typedef enum logic [2:0] {
    STAT_ADDED   = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_REQUEUE = 3'd2,
    STAT_FINISH  = 3'd3,
    STAT_IDLE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_INS,
    ST_PLACE0,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0]       cpu;
    logic [15:0]       need;
    logic signed [7:0] pri;
    logic [7:0]        id;
  } entry_t;

  typedef struct packed {
    logic [15:0] time_slice;
    logic [6:0]  priority_step;
  } cfg_t;

endpackage

>>> src/dps_cfg_regs.sv
// Configuration register file of the scheduler on an APB-style port.
`timescale 1ns / 1ps

module dps_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dps_pkg::PADDR_W-1:0]  paddr,
  input  logic [dps_pkg::PDATA_W-1:0]  pwdata,
  output logic [dps_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dps_pkg::cfg_t                cfg
);
  import dps_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_slice    <= TIME_SLICE_RESET;
      cfg.priority_step <= PRIORITY_STEP_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TIME_SLICE:    cfg.time_slice    <= pwdata[15:0];
        REG_PRIORITY_STEP: cfg.priority_step <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TIME_SLICE:    prdata = {16'd0, cfg.time_slice};
      REG_PRIORITY_STEP: prdata = {25'd0, cfg.priority_step};
      default:           prdata = '0;
    endcase
  end

endmodule

>>> src/dynamic_priority_scheduler_unit.sv
// Top level of the dynamic priority scheduler with its entry memory and control.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  add or run request
//   m_*       out        m_tvalid / m_tready  one result per request
//   p*        in/out     psel/penable/pready  time slice and priority step registers
//
// A request that neither pops nor walks the queue goes from idle straight to the result state,
// a pop passes the pop state first, and otherwise the sorted insert walks the entry memory
// from the tail, one entry per cycle through its single read and write port.
// Reset clears the entry count, head pointer and control; the memory is not cleared.
// One result register lets a new request be taken while the last result waits;
// a request that finishes before that result is taken waits in the result state.
`timescale 1ns / 1ps

module dynamic_priority_scheduler_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dps_pkg::PADDR_W-1:0]    paddr,
  input  logic [dps_pkg::PDATA_W-1:0]    pwdata,
  output logic [dps_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // proc_id [7:0], priority_req [15:8], need_time [31:16]
  input  logic [dps_pkg::S_TDATA_W-1:0]  s_tdata,
  // op [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // run_id [7:0], run_priority [15:8], run_need [31:16], run_cpu [47:32],
  // ready_count [52:48], zero fill [55:53]
  output logic [dps_pkg::M_TDATA_W-1:0]  m_tdata,
  // status [2:0]
  output logic [2:0]                     m_tuser
);
  import dps_pkg::*;

  cfg_t cfg;

  dps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] offs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t mem_q;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [PTR_W-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] idx, idx_next;
  entry_t           ins, ins_next;
  status_t          res_status, res_status_next;
  entry_t           res_entry, res_entry_next;
  logic             out_valid;
  logic [2:0]       out_tuser;
  logic [M_TDATA_W-1:0] out_tdata;

  logic             accept;
  logic             out_load;
  entry_t           in_entry;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [PTR_W-1:0] pop_head;
  logic             pop_go;
  logic signed [8:0] pri_drop;
  logic [16:0]      cpu_sum;
  entry_t           pop_entry;
  logic             ins_before;
  logic [PTR_W-1:0] idx_p1;
  logic [PTR_W-1:0] idx_m1;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_RESULT) && (!out_valid || m_tready);

  assign in_entry.id   = s_tdata[7:0];
  assign in_entry.pri  = s_tdata[15:8];
  assign in_entry.need = s_tdata[31:16];
  assign in_entry.cpu  = 16'd0;

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign pop_head = phys_addr(head, PTR_W'(1));
  assign idx_p1   = idx + PTR_W'(1);
  assign idx_m1   = idx - PTR_W'(1);

  assign pop_go   = mem_q.need > cfg.time_slice;
  assign pri_drop = 9'(mem_q.pri) - $signed({2'b00, cfg.priority_step});
  assign cpu_sum  = {1'b0, mem_q.cpu} + {1'b0, cfg.time_slice};

  always_comb begin
    pop_entry.id   = mem_q.id;
    pop_entry.pri  = (pri_drop < -9'sd128) ? -8'sd128 : pri_drop[7:0];
    pop_entry.cpu  = cpu_sum[16] ? 16'hFFFF : cpu_sum[15:0];
    pop_entry.need = mem_q.need - cfg.time_slice;
  end

  assign ins_before = $signed(ins.pri) > $signed(mem_q.pri);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_ADD) begin
            if (count == CNT_W'(QUEUE_DEPTH) || count == '0) begin
              state_next = ST_RESULT;
            end else begin
              state_next = ST_INS;
            end
          end else if (count == '0) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (pop_go && count != CNT_W'(1)) begin
          state_next = ST_INS;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_INS: begin
        if (!ins_before) begin
          state_next = ST_RESULT;
        end else if (idx == '0) begin
          state_next = ST_PLACE0;
        end
      end
      ST_PLACE0: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = head;
    mem_wdata       = ins;
    mem_raddr       = head;
    count_next      = count;
    head_next       = head;
    idx_next        = idx;
    ins_next        = ins;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_entry_next = '0;
          if (s_tuser == OP_ADD) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              res_status_next = STAT_FULL;
            end else begin
              res_status_next = STAT_ADDED;
              ins_next        = in_entry;
              if (count == '0) begin
                mem_we     = 1'b1;
                mem_waddr  = head;
                mem_wdata  = in_entry;
                count_next = CNT_W'(1);
              end else begin
                mem_raddr = phys_addr(head, cnt_m1[PTR_W-1:0]);
                idx_next  = cnt_m1[PTR_W-1:0];
              end
            end
          end else begin
            res_status_next = STAT_IDLE;
          end
        end
      end
      ST_POP: begin
        head_next = pop_head;
        if (pop_go) begin
          res_status_next = STAT_REQUEUE;
          res_entry_next  = pop_entry;
          ins_next        = pop_entry;
          if (count == CNT_W'(1)) begin
            mem_we    = 1'b1;
            mem_waddr = pop_head;
            mem_wdata = pop_entry;
          end else begin
            count_next = cnt_m1;
            mem_raddr  = phys_addr(pop_head, cnt_m2[PTR_W-1:0]);
            idx_next   = cnt_m2[PTR_W-1:0];
          end
        end else begin
          res_status_next = STAT_FINISH;
          res_entry_next  = mem_q;
          count_next      = cnt_m1;
        end
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = phys_addr(head, idx_p1);
        if (ins_before) begin
          mem_wdata = mem_q;
          mem_raddr = phys_addr(head, idx_m1);
          idx_next  = idx_m1;
        end else begin
          mem_wdata  = ins;
          count_next = count + CNT_W'(1);
        end
      end
      ST_PLACE0: begin
        mem_we     = 1'b1;
        mem_waddr  = head;
        mem_wdata  = ins;
        count_next = count + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    ins        <= ins_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    if (out_load) begin
      out_tuser <= res_status;
      out_tdata <= {3'd0, 5'(count), res_entry.cpu, res_entry.need,
                    res_entry.pri, res_entry.id};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_tdata;
  assign m_tuser  = out_tuser;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS || state == ST_PLACE0) |-> count < CNT_W'(QUEUE_DEPTH))
    else $error("insert into a full queue");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_status == STAT_FULL) |-> count == CNT_W'(QUEUE_DEPTH))
    else $error("full status with room in the queue");

  a_run_pops: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_RUN && count != '0) |=> state == ST_POP)
    else $error("run on a nonempty queue did not pop");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_RUN && count == '0) |=>
      (state == ST_RESULT && res_status == STAT_IDLE && $stable(count)))
    else $error("run on an empty queue changed the queue");

endmodule
